### rtl/tea_pkg.sv
package tea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  localparam logic [1:0] KEY_IDX0 = 2'd0;
  localparam logic [1:0] KEY_IDX1 = 2'd1;
  localparam logic [1:0] KEY_IDX2 = 2'd2;
  localparam logic [1:0] KEY_IDX3 = 2'd3;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [3:0][31:0] tea_key_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] w0;
    logic [31:0] w1;
  } tea_beat_t;

  // Running sum after a given number of delta additions, modulo 2^32.
  function automatic logic [31:0] tea_sum(input int unsigned mult);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(mult);
    return prod[31:0];
  endfunction

endpackage

### rtl/tea_cell.sv
module tea_cell
  import tea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tea_key_t    key,
  input  logic [31:0] enc_sum,
  input  logic [31:0] dec_sum,
  input  logic        second_half,
  input  logic        in_valid,
  output logic        in_ready,
  input  tea_beat_t   in_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output tea_beat_t   out_beat
);

  logic        valid;
  tea_beat_t   beat;
  logic        upd_w0;
  logic [31:0] sum;
  logic [31:0] x;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] dst;
  logic [31:0] res;
  tea_beat_t   beat_next;

  // Encryption updates the first word in the first half-round, decryption
  // walks the halves in reverse and updates the second word first.
  always_comb begin
    upd_w0 = ~(in_beat.cmd ^ second_half);
    sum    = (in_beat.cmd == CMD_DECRYPT) ? dec_sum : enc_sum;
    x      = upd_w0 ? in_beat.w1 : in_beat.w0;
    ka     = upd_w0 ? key[0] : key[2];
    kb     = upd_w0 ? key[1] : key[3];
    mix    = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    dst    = upd_w0 ? in_beat.w0 : in_beat.w1;
    res    = (in_beat.cmd == CMD_DECRYPT) ? (dst - mix) : (dst + mix);
    beat_next = in_beat;
    if (upd_w0) begin
      beat_next.w0 = res;
    end else begin
      beat_next.w1 = res;
    end
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;
  assign out_beat  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= beat_next;
    end
  end

endmodule

### rtl/tea_block_cipher_unit.sv
// From input to output each block passes through all 2*ROUNDS cells in turn.
// Throughput: one block per cycle unless stalled; each half-round is one cell.
// A cell takes a new beat when it is empty or its successor takes its beat, so
// input closes only once all 2*ROUNDS cells hold blocks behind a stalled output.
// Reset clears the key registers to zero and empties every cell.
module tea_block_cipher_unit
  import tea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // block_high, block_low
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // result_high, result_low
);

  tea_key_t  key;
  logic      valid [0:STAGES];
  logic      ready [0:STAGES];
  tea_beat_t beat  [0:STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        KEY_IDX0: key[0] <= cfg_data;
        KEY_IDX1: key[1] <= cfg_data;
        KEY_IDX2: key[2] <= cfg_data;
        KEY_IDX3: key[3] <= cfg_data;
        default:  key <= key;
      endcase
    end
  end

  assign valid[0]     = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign beat[0].cmd  = s_axis_tuser;
  assign beat[0].w0   = s_axis_tdata[31:0];
  assign beat[0].w1   = s_axis_tdata[63:32];

  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    localparam int unsigned Round = j / 2;
    localparam logic [31:0] EncSum = tea_sum(Round + 1);
    localparam logic [31:0] DecSum = tea_sum(ROUNDS - Round);
    localparam logic        HalfSel = 1'(j % 2);

    tea_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .key         (key),
      .enc_sum     (EncSum),
      .dec_sum     (DecSum),
      .second_half (HalfSel),
      .in_valid    (valid[j]),
      .in_ready    (ready[j]),
      .in_beat     (beat[j]),
      .out_valid   (valid[j+1]),
      .out_ready   (ready[j+1]),
      .out_beat    (beat[j+1])
    );
  end

  assign ready[STAGES] = m_axis_tready;
  assign m_axis_tvalid = valid[STAGES];
  assign m_axis_tdata  = {beat[STAGES].w1, beat[STAGES].w0};

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the last cell is empty");

  a_first_cell_ready: assert property (@(posedge clk) disable iff (rst)
    !valid[1] |-> s_axis_tready)
    else $error("input stalled while the first cell is empty");

endmodule
